// ===== rtl/core/dtc_pkg.sv =====
// Shared types, constants and helper functions for the date to tick count converter.
package dtc_pkg;

    // Floor division by a constant works on a 34-bit signed value.
    // The reciprocal is floor(2^34 / divisor).
    localparam logic [33:0] DIV_MIC   = 34'd1000000;
    localparam logic [31:0] MAG_MIC   = 32'd17179;
    localparam logic [33:0] DIV_60    = 34'd60;
    localparam logic [31:0] MAG_60    = 32'd286331153;
    localparam logic [33:0] DIV_24    = 34'd24;
    localparam logic [31:0] MAG_24    = 32'd715827882;
    localparam logic [33:0] DIV_12    = 34'd12;
    localparam logic [31:0] MAG_12    = 32'd1431655765;
    localparam logic [33:0] DIV_25    = 34'd25;
    localparam logic [31:0] MAG_25    = 32'd687194767;

    // Day number of 1601-01-01 on the March-based count, plus one for the one-based day.
    localparam logic signed [43:0] DAY_BIAS = 44'sd584695;
    // Number of days from 1601-01-01 up to 30828-01-01.
    localparam logic signed [43:0] DAY_SPAN = 44'sd10674942;

    // Divider state between the multiply stage and the correction stage.
    typedef struct packed {
        logic        neg;
        logic [33:0] u;
        logic [33:0] qe;
    } div_t;

    // Corrected floor quotient and non-negative remainder.
    typedef struct packed {
        logic signed [33:0] q;
        logic        [33:0] r;
    } fd_res_t;

    // Sign-extend a 32-bit field to the internal width.
    function automatic logic signed [33:0] sx34(input logic [31:0] v);
        return $signed({{2{v[31]}}, v});
    endfunction

    // Sign-extend an internal value to the day-count width.
    function automatic logic signed [43:0] sx44(input logic [33:0] v);
        return $signed({{10{v[33]}}, v});
    endfunction

    // Fold the sign away and estimate the quotient of the magnitude.
    function automatic div_t fd_start(input logic [33:0] v, input logic [31:0] mag);
        div_t        d;
        logic [65:0] p;
        d.neg = v[33];
        d.u   = v[33] ? ~v : v;
        p     = {32'd0, d.u} * {34'd0, mag};
        d.qe  = {2'b00, p[65:34]};
        return d;
    endfunction

    // Correct the estimate by at most one and restore the sign.
    function automatic fd_res_t fd_fix(input div_t d, input logic [33:0] dv);
        fd_res_t     res;
        logic [33:0] qd;
        logic [33:0] r;
        logic [33:0] qu;
        logic [33:0] ru;
        qd = d.qe * dv;
        r  = d.u - qd;
        if (r >= dv)
        begin
            qu = d.qe + 34'd1;
            ru = r - dv;
        end
        else
        begin
            qu = d.qe;
            ru = r;
        end
        // A negative value v = -u-1 has quotient -qu-1 and remainder dv-1-ru.
        res.q = d.neg ? $signed(~qu) : $signed(qu);
        res.r = d.neg ? (dv - 34'd1 - ru) : ru;
        return res;
    endfunction

    // Days from the first of March to the first of the month, month index 0 is January.
    function automatic logic [8:0] month_doy(input logic [3:0] mon);
        logic [8:0] d;
        unique case (mon)
            4'd0:    d = 9'd306;
            4'd1:    d = 9'd337;
            4'd2:    d = 9'd0;
            4'd3:    d = 9'd31;
            4'd4:    d = 9'd61;
            4'd5:    d = 9'd92;
            4'd6:    d = 9'd122;
            4'd7:    d = 9'd153;
            4'd8:    d = 9'd184;
            4'd9:    d = 9'd214;
            4'd10:   d = 9'd245;
            4'd11:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/date_fields_to_tick_count.sv =====
// Date to tick count converter: a seventeen-stage pipeline from calendar fields to ticks.
// Throughput is one request per cycle; busy is always low and the pipeline never stalls.
// The depth is set by the chain of carries: each floor division takes a multiply and a correction.
// Reset clears the stage valid bits only; no result strobes until a request has passed through.
module date_fields_to_tick_count (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] year_in,
    input  logic signed [31:0] month_in,
    input  logic signed [31:0] day_in,
    input  logic signed [31:0] hour_in,
    input  logic signed [31:0] minute_in,
    input  logic signed [31:0] second_in,
    input  logic signed [31:0] microsecond_in,
    output logic               done,
    output logic [62:0]        tick_count,
    output logic               invalid
);

    localparam int LAT = 17;

    // Stage valid bits.
    logic [LAT:1] vld_reg;

    // Field carriers, indexed by the stage that holds them.
    logic signed [33:0] year_reg [1:3];
    logic        [3:0]  mon_reg  [2:3];
    logic signed [33:0] day_reg  [1:12];
    logic signed [33:0] hour_reg [1:13];
    logic signed [33:0] min_reg  [1:13];
    logic signed [33:0] sec_reg  [1:13];
    logic        [19:0] mic_reg  [2:15];
    logic signed [33:0] yy_reg   [4:6];
    logic        [8:0]  doy_reg  [4:7];
    logic signed [43:0] base_reg [8:12];
    logic               bad_reg  [13:16];

    // Divider state and carries.
    dtc_pkg::div_t      mic_d_reg;
    dtc_pkg::div_t      mon_d_reg;
    dtc_pkg::div_t      sec_d_reg;
    dtc_pkg::div_t      yyd_reg;
    dtc_pkg::div_t      min_d_reg;
    dtc_pkg::div_t      hour_d_reg;
    logic signed [33:0] q_mic_reg;
    logic signed [33:0] q_mon_reg;
    logic signed [33:0] q_sec_reg;
    logic signed [33:0] q_min_reg;
    logic signed [33:0] q_hour_reg;
    logic signed [33:0] f100_reg;
    logic signed [43:0] t1_reg;
    logic signed [43:0] t2_reg;

    // Final arithmetic.
    logic [23:0]        rel_reg;
    logic [39:0]        a_reg;
    logic [16:0]        b_reg;
    logic [39:0]        sd_reg;
    logic [43:0]        ph_reg;
    logic [43:0]        pl_reg;
    logic [23:0]        um_reg;
    logic [62:0]        tick_count_reg;
    logic               invalid_reg;

    dtc_pkg::fd_res_t   mic_fix;
    dtc_pkg::fd_res_t   mon_fix;
    dtc_pkg::fd_res_t   sec_fix;
    dtc_pkg::fd_res_t   yy_fix;
    dtc_pkg::fd_res_t   min_fix;
    dtc_pkg::fd_res_t   hour_fix;
    logic signed [43:0] rel_next;
    logic [63:0]        tick_next;

    // Correction stages of the floor dividers.
    assign mic_fix  = dtc_pkg::fd_fix(mic_d_reg, dtc_pkg::DIV_MIC);
    assign mon_fix  = dtc_pkg::fd_fix(mon_d_reg, dtc_pkg::DIV_12);
    assign sec_fix  = dtc_pkg::fd_fix(sec_d_reg, dtc_pkg::DIV_60);
    assign yy_fix   = dtc_pkg::fd_fix(yyd_reg, dtc_pkg::DIV_25);
    assign min_fix  = dtc_pkg::fd_fix(min_d_reg, dtc_pkg::DIV_60);
    assign hour_fix = dtc_pkg::fd_fix(hour_d_reg, dtc_pkg::DIV_24);

    // Day offset from 1601-01-01 and the final tick sum.
    assign rel_next  = base_reg[12] + dtc_pkg::sx44(day_reg[12]);
    assign tick_next = {ph_reg, 20'd0} + {20'd0, pl_reg} + {40'd0, um_reg};

    // Valid bits travel with each request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-1:1], start};
        end
    end

    // Payload pipeline: fields shift along, except at the stages that work on them.
    always_ff @(posedge clk)
    begin
        year_reg[2] <= year_reg[1];
        for (int k = 2; k <= 11; k++)
        begin
            day_reg[k] <= day_reg[k-1];
        end
        for (int k = 2; k <= 8; k++)
        begin
            hour_reg[k] <= hour_reg[k-1];
        end
        for (int k = 12; k <= 13; k++)
        begin
            hour_reg[k] <= hour_reg[k-1];
        end
        for (int k = 2; k <= 5; k++)
        begin
            min_reg[k] <= min_reg[k-1];
        end
        for (int k = 9; k <= 13; k++)
        begin
            min_reg[k] <= min_reg[k-1];
        end
        sec_reg[2] <= sec_reg[1];
        for (int k = 6; k <= 13; k++)
        begin
            sec_reg[k] <= sec_reg[k-1];
        end
        for (int k = 3; k <= 15; k++)
        begin
            mic_reg[k] <= mic_reg[k-1];
        end
        for (int k = 5; k <= 6; k++)
        begin
            yy_reg[k] <= yy_reg[k-1];
        end
        for (int k = 5; k <= 7; k++)
        begin
            doy_reg[k] <= doy_reg[k-1];
        end
        for (int k = 9; k <= 12; k++)
        begin
            base_reg[k] <= base_reg[k-1];
        end
        for (int k = 14; k <= 16; k++)
        begin
            bad_reg[k] <= bad_reg[k-1];
        end

        // Stage 1: capture the request and start the microsecond and month dividers.
        year_reg[1] <= dtc_pkg::sx34(year_in);
        day_reg[1]  <= dtc_pkg::sx34(day_in);
        hour_reg[1] <= dtc_pkg::sx34(hour_in);
        min_reg[1]  <= dtc_pkg::sx34(minute_in);
        sec_reg[1]  <= dtc_pkg::sx34(second_in);
        mic_d_reg   <= dtc_pkg::fd_start(dtc_pkg::sx34(microsecond_in), dtc_pkg::MAG_MIC);
        mon_d_reg   <= dtc_pkg::fd_start(dtc_pkg::sx34(month_in) - 34'sd1, dtc_pkg::MAG_12);

        // Stage 2: microsecond and zero-based month remainders with their carries.
        mic_reg[2] <= mic_fix.r[19:0];
        q_mic_reg  <= mic_fix.q;
        mon_reg[2] <= mon_fix.r[3:0];
        q_mon_reg  <= mon_fix.q;

        // Stage 3: carry into seconds and years.
        sec_reg[3]  <= sec_reg[2] + q_mic_reg;
        year_reg[3] <= year_reg[2] + q_mon_reg;
        mon_reg[3]  <= mon_reg[2];

        // Stage 4: start the seconds divider; January and February belong to the year before.
        sec_d_reg  <= dtc_pkg::fd_start(sec_reg[3], dtc_pkg::MAG_60);
        yy_reg[4]  <= year_reg[3] - ((mon_reg[3] < 4'd2) ? 34'sd1 : 34'sd0);
        doy_reg[4] <= dtc_pkg::month_doy(mon_reg[3]);

        // Stage 5: seconds remainder; start the century divider on floor(year / 4).
        sec_reg[5] <= $signed(sec_fix.r);
        q_sec_reg  <= sec_fix.q;
        yyd_reg    <= dtc_pkg::fd_start(yy_reg[4] >>> 2, dtc_pkg::MAG_25);

        // Stage 6: carry into minutes; floor(year / 100).
        min_reg[6] <= min_reg[5] + q_sec_reg;
        f100_reg   <= yy_fix.q;

        // Stage 7: start the minutes divider; day count of the year start, in two parts.
        min_d_reg <= dtc_pkg::fd_start(min_reg[6], dtc_pkg::MAG_60);
        t1_reg    <= dtc_pkg::sx44(yy_reg[6]) * 44'sd365;
        t2_reg    <= dtc_pkg::sx44(yy_reg[6] >>> 2) - dtc_pkg::sx44(f100_reg)
                     + dtc_pkg::sx44(f100_reg >>> 2);

        // Stage 8: minutes remainder; day number of the month start relative to 1601.
        min_reg[8]  <= $signed(min_fix.r);
        q_min_reg   <= min_fix.q;
        base_reg[8] <= t1_reg + t2_reg + $signed({35'd0, doy_reg[7]}) - dtc_pkg::DAY_BIAS;

        // Stage 9: carry into hours.
        hour_reg[9] <= hour_reg[8] + q_min_reg;

        // Stage 10: start the hours divider.
        hour_d_reg <= dtc_pkg::fd_start(hour_reg[9], dtc_pkg::MAG_24);

        // Stage 11: hours remainder.
        hour_reg[11] <= $signed(hour_fix.r);
        q_hour_reg   <= hour_fix.q;

        // Stage 12: carry into days.
        day_reg[12] <= day_reg[11] + q_hour_reg;

        // Stage 13: absolute day and range check.
        rel_reg     <= rel_next[23:0];
        bad_reg[13] <= (rel_next < 44'sd0) || (rel_next >= dtc_pkg::DAY_SPAN);

        // Stage 14: whole days in seconds, and seconds within the day.
        a_reg <= {16'd0, rel_reg} * 40'd86400;
        b_reg <= {12'd0, hour_reg[13][4:0]} * 17'd3600
                 + {11'd0, min_reg[13][5:0]} * 17'd60
                 + {11'd0, sec_reg[13][5:0]};

        // Stage 15: total seconds.
        sd_reg <= a_reg + {23'd0, b_reg};

        // Stage 16: seconds to ticks in two partial products, microseconds to ticks.
        ph_reg <= {24'd0, sd_reg[39:20]} * 44'd10000000;
        pl_reg <= {24'd0, sd_reg[19:0]} * 44'd10000000;
        um_reg <= {4'd0, mic_reg[15]} * 24'd10;

        // Stage 17: result register.
        tick_count_reg <= bad_reg[16] ? 63'd0 : tick_next[62:0];
        invalid_reg    <= bad_reg[16];
    end

    assign busy       = 1'b0;
    assign done       = vld_reg[LAT];
    assign tick_count = tick_count_reg;
    assign invalid    = invalid_reg;

    // A result only follows a request that has passed through every stage.
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result strobe without a matching request");

    // An invalid result carries a zero tick count.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (tick_count == 63'd0))
        else $error("invalid result with a non-zero tick count");

endmodule
